[rtl/gif_lzw_pkg.sv]
// Shared types and constants of the GIF LZW encoder.
// No dependencies; every other file of the block but gif_lzw_if uses it.
package gif_lzw_pkg;

   localparam int PIX_W     = 8;
   localparam int CODE_W    = 12;
   localparam int WIDTH_W   = 4;
   localparam int FREE_W    = CODE_W + 1;
   localparam int HASH_W    = 13;
   localparam int EPOCH_W   = 8;
   localparam int KEY_W     = CODE_W + PIX_W;
   localparam int PACK_W    = 20;
   localparam int PCNT_W    = 5;

   localparam logic [CODE_W-1:0]  CLEAR_CODE    = 12'd256;
   localparam logic [CODE_W-1:0]  END_CODE      = 12'd257;
   localparam logic [FREE_W-1:0]  FIRST_FREE    = 13'd258;
   localparam logic [FREE_W-1:0]  TABLE_CODES   = 13'd4096;
   localparam logic [WIDTH_W-1:0] START_WIDTH   = 4'd9;
   localparam logic [WIDTH_W-1:0] MAX_CODE_BITS = 4'd12;

   // one pixel as classified by the front end
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             eof;
      logic             first;
   } item_type;

   // one code handed to the bit packer
   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [WIDTH_W-1:0] width;
      logic               flush;
   } code_req_type;

   // one slot of the hashed dictionary
   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [KEY_W-1:0]   key;
      logic [CODE_W-1:0]  code;
   } entry_type;

endpackage

[rtl/gif_lzw_if.sv]
// Valid/ready channel interfaces for pixel items and stream bytes.
// No dependencies.
interface gif_lzw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_index;
   logic       end_of_frame;
   modport source (output valid, pixel_index, end_of_frame, input ready);
   modport sink   (input valid, pixel_index, end_of_frame, output ready);
endinterface

interface gif_lzw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       stream_end;
   modport source (output valid, code_byte, stream_end, input ready);
   modport sink   (input valid, code_byte, stream_end, output ready);
endinterface

[rtl/gif_lzw_fifo.sv]
// Two-entry item queue between the front end and the dictionary engine.
// Depends on gif_lzw_pkg.
module gif_lzw_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gif_lzw_pkg::item_type push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output gif_lzw_pkg::item_type pop_item
);
   gif_lzw_pkg::item_type slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff,  cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_item  = slot_ff[rptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop  ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end
endmodule

[rtl/gif_lzw_front.sv]
// Front end: takes pixel items and marks the first pixel of each frame.
// Depends on gif_lzw_pkg and gif_lzw_if.
module gif_lzw_front (
   input  logic                  clock,
   input  logic                  reset,
   gif_lzw_req_if.sink           req_chan,
   input  logic                  q_full,
   output logic                  q_push,
   output gif_lzw_pkg::item_type q_item
);
   logic in_frame_ff, in_frame_in;

   assign req_chan.ready = ~q_full;
   assign q_push         = req_chan.valid & ~q_full;

   // classify: first pixel after reset or after a frame end
   always_comb begin
      q_item.pix   = req_chan.pixel_index;
      q_item.eof   = req_chan.end_of_frame;
      q_item.first = ~in_frame_ff;
      in_frame_in  = q_push ? ~req_chan.end_of_frame : in_frame_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end
endmodule

[rtl/gif_lzw_pack.sv]
// Bit packer: packs variable-width codes LSB first and drives the byte channel.
// Depends on gif_lzw_pkg and gif_lzw_if.
module gif_lzw_pack (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      code_valid,
   input  gif_lzw_pkg::code_req_type code_req,
   output logic                      code_ready,
   gif_lzw_rsp_if.source             rsp_chan
);
   logic [gif_lzw_pkg::PACK_W-1:0] buf_ff, buf_in;
   logic [gif_lzw_pkg::PCNT_W-1:0] cnt_ff, cnt_in;
   logic       flush_ff, flush_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;
   logic       can_out, emit, take, last;
   logic [gif_lzw_pkg::CODE_W-1:0] masked;

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.code_byte  = out_byte_ff;
   assign rsp_chan.stream_end = out_end_ff;

   assign code_ready = (cnt_ff < 5'd8) & ~flush_ff;

   always_comb begin
      // keep only the low width bits of the code
      for (int i = 0; i < gif_lzw_pkg::CODE_W; i++) begin
         masked[i] = code_req.code[i] & (4'(i) < code_req.width);
      end
      can_out = ~out_valid_ff | rsp_chan.ready;
      take    = code_valid & code_ready;
      emit    = can_out & ((cnt_ff >= 5'd8) | (flush_ff & (cnt_ff != 5'd0)));
      last    = flush_ff & (cnt_ff <= 5'd8);

      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      flush_in     = flush_ff;
      out_valid_in = out_valid_ff & ~rsp_chan.ready;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;

      if (take) begin
         buf_in   = buf_ff | (20'(masked) << cnt_ff);
         cnt_in   = cnt_ff + 5'(code_req.width);
         flush_in = code_req.flush;
      end else if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = buf_ff[7:0];
         out_end_in   = last;
         if (last) begin
            buf_in   = '0;
            cnt_in   = '0;
            flush_in = 1'b0;
         end else begin
            buf_in = buf_ff >> 8;
            cnt_in = cnt_ff - 5'd8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < 5'd20) else $error("pack count overflow");
   a_flush_clean: assert property (@(posedge clock) disable iff (reset)
      (emit & last) |=> (cnt_ff == 5'd0) && (buf_ff == '0))
      else $error("packer not clean after stream end");
   a_no_take_flush: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> !take) else $error("code taken while flushing");
endmodule

[rtl/gif_lzw_dict.sv]
// Dictionary engine: hashed string table with linear probing and epoch tags,
// code sequencing per pixel. Depends on gif_lzw_pkg.
module gif_lzw_dict (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  gif_lzw_pkg::item_type     q_item,
   output logic                      q_pop,
   output logic                      code_valid,
   output gif_lzw_pkg::code_req_type code_req,
   input  logic                      code_ready
);
   typedef enum logic [2:0] {
      S_WIPE, S_IDLE, S_CHECK, S_MISS, S_CLEAR, S_TAIL, S_END
   } state_type;

   localparam int HW = gif_lzw_pkg::HASH_W;
   localparam int CW = gif_lzw_pkg::CODE_W;
   localparam int FW = gif_lzw_pkg::FREE_W;
   localparam int WW = gif_lzw_pkg::WIDTH_W;
   localparam int EW = gif_lzw_pkg::EPOCH_W;

   gif_lzw_pkg::entry_type mem [2**HW];
   gif_lzw_pkg::entry_type rdata_ff, mem_wdata;
   logic          mem_we, mem_re;
   logic [HW-1:0] mem_waddr, mem_raddr;

   state_type     state_ff, state_in;
   logic [CW-1:0] prefix_ff, prefix_in;
   logic [FW-1:0] free_ff, free_in, free_nx;
   logic [WW-1:0] width_ff, width_in;
   logic [EW-1:0] epoch_ff, epoch_in;
   logic [HW-1:0] probe_ff, probe_in;
   logic [HW-1:0] wipe_ff, wipe_in;
   logic          wipe_pend_ff, wipe_pend_in;
   logic [gif_lzw_pkg::PIX_W-1:0] pix_ff, pix_in;
   logic          eof_ff, eof_in;
   logic [gif_lzw_pkg::KEY_W-1:0] key;

   // dictionary memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      prefix_in    = prefix_ff;
      free_in      = free_ff;
      width_in     = width_ff;
      epoch_in     = epoch_ff;
      probe_in     = probe_ff;
      wipe_in      = wipe_ff;
      wipe_pend_in = wipe_pend_ff;
      pix_in       = pix_ff;
      eof_in       = eof_ff;
      q_pop        = 1'b0;
      code_valid   = 1'b0;
      code_req     = '{code: prefix_ff, width: width_ff, flush: 1'b0};
      mem_we       = 1'b0;
      mem_waddr    = probe_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = probe_ff + 1'b1;
      key          = {prefix_ff, pix_ff};
      free_nx      = (free_ff < gif_lzw_pkg::TABLE_CODES) ? free_ff + 1'b1 : free_ff;

      case (state_ff)
         S_WIPE: begin
            // clearing pass: every tag back to the never-valid epoch
            mem_we    = 1'b1;
            mem_waddr = wipe_ff;
            wipe_in   = wipe_ff + 1'b1;
            if (&wipe_ff) begin
               state_in     = S_IDLE;
               epoch_in     = EW'(1);
               wipe_pend_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (wipe_pend_ff) begin
               state_in = S_WIPE;
               wipe_in  = '0;
            end else if (q_valid) begin
               q_pop  = 1'b1;
               pix_in = q_item.pix;
               eof_in = q_item.eof;
               if (q_item.first) begin
                  free_in   = gif_lzw_pkg::FIRST_FREE;
                  width_in  = gif_lzw_pkg::START_WIDTH;
                  prefix_in = CW'(q_item.pix);
                  state_in  = S_CLEAR;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = (HW'(q_item.pix) << (HW - gif_lzw_pkg::PIX_W)) ^
                              HW'(prefix_ff);
                  probe_in  = mem_raddr;
                  state_in  = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (rdata_ff.tag == epoch_ff) begin
               if (rdata_ff.key == key) begin
                  prefix_in = rdata_ff.code;
                  state_in  = S_TAIL;
               end else begin
                  mem_re   = 1'b1;
                  probe_in = mem_raddr;
               end
            end else begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            // emit the string code, add the new string in the empty slot
            code_valid = 1'b1;
            if (code_ready) begin
               if (free_ff < gif_lzw_pkg::TABLE_CODES) begin
                  mem_we    = 1'b1;
                  mem_wdata = '{tag: epoch_ff, key: key, code: free_ff[CW-1:0]};
                  free_in   = free_nx;
                  if ((free_nx > (FW'(1) << width_ff)) &&
                      (width_ff < gif_lzw_pkg::MAX_CODE_BITS)) begin
                     width_in = width_ff + 1'b1;
                  end
               end
               prefix_in = CW'(pix_ff);
               state_in  = (free_nx >= gif_lzw_pkg::TABLE_CODES) ? S_CLEAR : S_TAIL;
            end
         end
         S_CLEAR: begin
            // clear code, then a fresh table generation
            code_valid    = 1'b1;
            code_req.code = gif_lzw_pkg::CLEAR_CODE;
            if (code_ready) begin
               free_in  = gif_lzw_pkg::FIRST_FREE;
               width_in = gif_lzw_pkg::START_WIDTH;
               epoch_in = epoch_ff + 1'b1;
               if (&epoch_ff) begin
                  wipe_pend_in = 1'b1;
               end
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (eof_ff) begin
               code_valid = 1'b1;
               if (code_ready) begin
                  state_in = S_END;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_END: begin
            code_valid     = 1'b1;
            code_req.code  = gif_lzw_pkg::END_CODE;
            code_req.flush = 1'b1;
            if (code_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         prefix_ff    <= '0;
         free_ff      <= gif_lzw_pkg::FIRST_FREE;
         width_ff     <= gif_lzw_pkg::START_WIDTH;
         epoch_ff     <= EW'(1);
         wipe_ff      <= '0;
         wipe_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         free_ff      <= free_in;
         width_ff     <= width_in;
         epoch_ff     <= epoch_in;
         wipe_ff      <= wipe_in;
         wipe_pend_ff <= wipe_pend_in;
      end
      probe_ff <= probe_in;
      pix_ff   <= pix_in;
      eof_ff   <= eof_in;
   end

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      (free_ff >= gif_lzw_pkg::FIRST_FREE) && (free_ff <= gif_lzw_pkg::TABLE_CODES))
      else $error("free code out of range");
   a_width_fits: assert property (@(posedge clock) disable iff (reset)
      (width_ff == gif_lzw_pkg::MAX_CODE_BITS) || (free_ff <= (FW'(1) << width_ff)))
      else $error("code width lags free code");
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= gif_lzw_pkg::START_WIDTH) && (width_ff <= gif_lzw_pkg::MAX_CODE_BITS))
      else $error("code width out of range");
endmodule

[rtl/gif_lzw_encoder_core.sv]
// Top level of the GIF LZW encoder.
// Depends on gif_lzw_pkg, gif_lzw_if, gif_lzw_fifo, gif_lzw_front,
// gif_lzw_dict and gif_lzw_pack.
//
// req_chan carries one palette index per item, end_of_frame set on the last
// pixel of a frame. rsp_chan carries the packed LZW byte stream, stream_end
// set on the frame's final byte. Both are valid/ready channels.
// A front end marks frame starts and feeds a two-entry queue; the dictionary
// engine takes one item at a time from it. A pixel that continues a string
// passes the states pop and read, compare and tail, with one more compare
// per extra hash probe in the 8192-slot dictionary memory (one registered
// read per cycle); a miss, a clear code and the end code each add a state,
// which waits while the packer is not ready. Bytes leave at most one per
// cycle from the packer's output register; each code waits until the packer
// holds less than one full byte and is not flushing. After reset the engine
// runs a clearing pass over all 8192 dictionary slots before it takes an
// item (the queue still fills); the same pass runs after every 255 table
// generations (254 for the first one after reset). A stalled receiver backs
// up into the packer, the engine, the queue and finally req_chan.ready.
module gif_lzw_encoder_core (
   input  logic          clock,
   input  logic          reset,
   gif_lzw_req_if.sink   req_chan,
   gif_lzw_rsp_if.source rsp_chan
);
   gif_lzw_pkg::item_type     f_item, q_item;
   gif_lzw_pkg::code_req_type code_req;
   logic q_push, q_full, q_pop, q_valid;
   logic code_valid, code_ready;

   gif_lzw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (f_item)
   );

   gif_lzw_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (q_item)
   );

   gif_lzw_dict u_dict (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .code_valid (code_valid),
      .code_req   (code_req),
      .code_ready (code_ready)
   );

   gif_lzw_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .code_valid (code_valid),
      .code_req   (code_req),
      .code_ready (code_ready),
      .rsp_chan   (rsp_chan)
   );
endmodule
